FILE: hdl/ldfw_pkg.sv
// Shared types and constants for the decimal field writer.
// No dependencies; the other design files and the checker refer to it by scoped names.
package ldfw_pkg;

  localparam int unsigned NUM_W       = 17;
  localparam int unsigned COL_W       = 6;
  localparam int unsigned PLACE_W     = 14;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FIELD_BYTES = 6;
  localparam int unsigned CNT_W       = 3;

  localparam logic [NUM_W-1:0]   NUM_MAX     = 17'd99999;
  localparam logic [PLACE_W-1:0] PLACE_10000 = 14'd10000;
  localparam logic [PLACE_W-1:0] PLACE_1000  = 14'd1000;
  localparam logic [PLACE_W-1:0] PLACE_100   = 14'd100;
  localparam logic [PLACE_W-1:0] PLACE_10    = 14'd10;
  localparam logic [BYTE_W-1:0]  ASCII_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0]  ASCII_SPACE = 8'h20;

  // Item in flight through the digit pipeline. digits[3] is the
  // ten-thousands digit once all four stages are passed, digits[0] the tens.
  typedef struct packed {
    logic [NUM_W-1:0]              rem;
    logic [BYTE_W-1:0]             cmd;
    logic [3:0][DIGIT_W-1:0]       digits;
  } work_t;

endpackage

FILE: hdl/ldfw_digit_stage.sv
// One register stage of the digit pipeline: split off the leading digit
// for a given place value. Depends on ldfw_pkg.
module ldfw_digit_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ldfw_pkg::PLACE_W-1:0]    place,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  ldfw_pkg::work_t                 up_data,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output ldfw_pkg::work_t                 dn_data
);

  logic            vld_r;
  ldfw_pkg::work_t data_r;
  ldfw_pkg::work_t data_nxt;
  logic [ldfw_pkg::DIGIT_W-1:0] digit;
  logic [ldfw_pkg::NUM_W-1:0]   place_ext;

  assign place_ext = {{(ldfw_pkg::NUM_W-ldfw_pkg::PLACE_W){1'b0}}, place};

  // Compare against each multiple in parallel; the remainder is below ten
  // places, so the largest passing multiple is the digit.
  always_comb begin
    digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (up_data.rem >= ldfw_pkg::NUM_W'(k * place_ext)) begin
        digit = ldfw_pkg::DIGIT_W'(k);
      end
    end
  end

  always_comb begin
    data_nxt        = up_data;
    data_nxt.rem    = up_data.rem - ldfw_pkg::NUM_W'(digit * place_ext);
    data_nxt.digits = {up_data.digits[2:0], digit};
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

FILE: hdl/ldfw_serializer.sv
// Output serializer: blank leading zeros, build the six display bytes and
// send them one per cycle while out_tready is high. Depends on ldfw_pkg.
module ldfw_serializer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  ldfw_pkg::work_t               up_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ldfw_pkg::BYTE_W-1:0]   out_tdata,
  output logic                          out_tuser,
  output logic                          out_tlast
);

  localparam logic [ldfw_pkg::CNT_W-1:0] CNT_FULL = ldfw_pkg::CNT_W'(ldfw_pkg::FIELD_BYTES);
  localparam logic [ldfw_pkg::CNT_W-1:0] CNT_ONE  = ldfw_pkg::CNT_W'(1);

  logic [ldfw_pkg::FIELD_BYTES-1:0][ldfw_pkg::BYTE_W-1:0] bytes_r, bytes_nxt, load_bytes;
  logic [ldfw_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [4:0][ldfw_pkg::DIGIT_W-1:0] dig;
  logic [4:0] shown;
  logic take_out, load;

  // dig[4] is ten-thousands, dig[0] units.
  assign dig = {up_data.digits, up_data.rem[ldfw_pkg::DIGIT_W-1:0]};

  always_comb begin
    shown[4] = (dig[4] != '0);
    for (int i = 3; i >= 1; i--) begin
      shown[i] = shown[i+1] || (dig[i] != '0);
    end
    shown[0] = 1'b1;
    load_bytes[0] = up_data.cmd;
    for (int i = 0; i < 5; i++) begin
      load_bytes[5-i] = shown[i] ? (ldfw_pkg::ASCII_ZERO | {4'h0, dig[i]})
                                 : ldfw_pkg::ASCII_SPACE;
    end
  end

  assign take_out = out_tvalid && out_tready;
  assign up_ready = (cnt_r == '0) || ((cnt_r == CNT_ONE) && out_tready);
  assign load     = up_ready && up_valid;

  always_comb begin
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    if (load) begin
      cnt_nxt   = CNT_FULL;
      bytes_nxt = load_bytes;
    end else if (take_out) begin
      cnt_nxt   = cnt_r - CNT_ONE;
      bytes_nxt = bytes_r >> ldfw_pkg::BYTE_W;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = bytes_r[0];
  assign out_tuser  = (cnt_r != CNT_FULL);
  assign out_tlast  = (cnt_r == CNT_ONE);

endmodule

FILE: hdl/lcd_decimal_field_writer.sv
// Top level of the decimal field writer: clamp, four digit stages and the
// output serializer. Depends on ldfw_pkg, ldfw_digit_stage, ldfw_serializer.
//
// Each input item (number, row, column) yields six items on the output: a
// set-position command ({1, row, column}, tuser low) and then five ASCII
// characters of the number, most significant first, with leading zeros
// shown as spaces and the units digit always shown (tuser high, tlast on the
// sixth). Numbers above 99999 print as 99999. The output channel moves one
// byte per cycle while out_tready is high; the next item loads into the
// serializer in the cycle its predecessor's last byte is taken, so the byte
// stream runs without gaps. An accepted item passes the four digit stages
// and then the serializer load register before its first byte goes out.
// Up to four further items queue in the digit pipeline while the serializer
// is busy.
module lcd_decimal_field_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [16:0] number, [17] row, [23:18] column
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] lcd_byte
  output logic        out_tuser,  // [0] is_data
  output logic        out_tlast
);

  logic [ldfw_pkg::NUM_W-1:0] number;
  logic                       row;
  logic [ldfw_pkg::COL_W-1:0] column;
  ldfw_pkg::work_t            entry;

  logic            [4:0] vld;
  logic            [4:0] rdy;
  ldfw_pkg::work_t [4:0] wrk;
  logic [3:0][ldfw_pkg::PLACE_W-1:0] places;

  assign number = in_tdata[16:0];
  assign row    = in_tdata[17];
  assign column = in_tdata[23:18];

  // Clamp and form the position command: 0x80 | column or 0xC0 | column.
  always_comb begin
    entry.rem    = (number > ldfw_pkg::NUM_MAX) ? ldfw_pkg::NUM_MAX : number;
    entry.cmd    = {1'b1, row, column};
    entry.digits = '0;
  end

  assign places = {ldfw_pkg::PLACE_10, ldfw_pkg::PLACE_100,
                   ldfw_pkg::PLACE_1000, ldfw_pkg::PLACE_10000};

  assign vld[0]    = in_tvalid;
  assign wrk[0]    = entry;
  assign in_tready = rdy[0];

  // Split one digit per stage, ten-thousands first.
  for (genvar s = 0; s < 4; s++) begin : g_stage
    ldfw_digit_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .place    (places[s]),
      .up_valid (vld[s]),
      .up_ready (rdy[s]),
      .up_data  (wrk[s]),
      .dn_valid (vld[s+1]),
      .dn_ready (rdy[s+1]),
      .dn_data  (wrk[s+1])
    );
  end

  ldfw_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (vld[4]),
    .up_ready   (rdy[4]),
    .up_data    (wrk[4]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // The final byte of a run is always a character.
  a_last_is_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last byte is not a character");

  // A command byte always carries the set-position bit.
  a_cmd_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7])
    else $error("command byte without set-position bit");

  // Characters follow a taken command without a gap.
  a_cmd_then_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tuser |=> out_tvalid && out_tuser)
    else $error("no character after command");

  // Every character is a space or a decimal digit.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata == 8'h20) || ((out_tdata >= 8'h30) && (out_tdata <= 8'h39)))
    else $error("character out of set");

endmodule

FILE: sim/ldfw_field_checker.sv
// Checker for the decimal field writer: watches both streams, predicts the six
// display bytes of every accepted item and compares them in order.
// Depends on ldfw_pkg for the ASCII constants and the number clamp.
module ldfw_field_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [16:0] number, [17] row, [23:18] column
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] lcd_byte
  input  logic        out_tuser,  // [0] is_data
  input  logic        out_tlast,
  output int          fail_count,
  output int          bytes_owed
);

  localparam logic [7:0] SET_POS_ROW0 = 8'h80;
  localparam logic [7:0] SET_POS_ROW1 = 8'hC0;
  localparam int         FIELD_DIGITS = 5;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
  } lcd_out_t;

  lcd_out_t bytes_due [$];

  // Queue the set-position command and the five characters of one field.
  task automatic queue_field(input logic [23:0] item);
    int       value;
    int       place;
    int       digit;
    bit       shown;
    lcd_out_t b;
    value = int'(item[16:0]);
    if (value > int'(ldfw_pkg::NUM_MAX)) value = int'(ldfw_pkg::NUM_MAX);
    b.lcd_byte = (item[17] ? SET_POS_ROW1 : SET_POS_ROW0) | {2'b00, item[23:18]};
    b.is_data  = 1'b0;
    b.last     = 1'b0;
    bytes_due.push_back(b);
    place = 10000;
    shown = 1'b0;
    for (int i = 0; i < FIELD_DIGITS; i++) begin
      digit = value / place;
      value = value - digit * place;
      if (digit != 0 || i == FIELD_DIGITS - 1) shown = 1'b1;
      b.lcd_byte = shown ? ldfw_pkg::ASCII_ZERO + 8'(digit) : ldfw_pkg::ASCII_SPACE;
      b.is_data  = 1'b1;
      b.last     = (i == FIELD_DIGITS - 1);
      bytes_due.push_back(b);
      place = place / 10;
    end
  endtask

  initial begin
    fail_count = 0;
    bytes_owed = 0;
  end

  always @(posedge clk) begin
    lcd_out_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) queue_field(in_tdata);
      if (out_tvalid && out_tready) begin
        if (bytes_due.size() == 0) begin
          $error("unexpected result: lcd_byte %h, is_data %b, last %b",
                 out_tdata, out_tuser, out_tlast);
          fail_count++;
        end else begin
          want = bytes_due.pop_front();
          if (out_tdata !== want.lcd_byte) begin
            $error("lcd_byte: expected %h, got %h", want.lcd_byte, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.is_data) begin
            $error("is_data: expected %b, got %b", want.is_data, out_tuser);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_tlast);
            fail_count++;
          end
        end
      end
      bytes_owed = bytes_due.size();
    end
  end

endmodule

FILE: sim/lcd_decimal_field_writer_test.sv
// Testbench top for the decimal field writer: clock, reset, stimulus and
// verdict. Depends on lcd_decimal_field_writer and ldfw_field_checker.
module lcd_decimal_field_writer_test;

  localparam int RANDOM_PER_PHASE = 28;
  localparam int RANDOM_PHASES    = 5;
  localparam int HOLD_CYCLES      = 80;
  localparam int HOLD_ITEMS       = 14;
  localparam int TAIL_CYCLES      = 20;
  localparam int CYCLE_LIMIT      = 200000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [16:0] number, [17] row, [23:18] column
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] lcd_byte
  logic        out_tuser;         // [0] is_data
  logic        out_tlast;

  int          fail_count;
  int          bytes_owed;
  int          rx_stall_pct = 0;
  int          tx_idle_pct  = 0;
  int          cycles       = 0;
  int          hold_left    = 0;
  logic [7:0]  hold_req     = '0;
  logic [7:0]  hold_seen    = '0;

  lcd_decimal_field_writer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  ldfw_field_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .bytes_owed (bytes_owed)
  );

  always #1 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[lcd_decimal_field_writer] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever the stimulus
  // bumps hold_req. The hold is counted here so the sender can keep pushing
  // items into the block meanwhile.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one item, with random idle cycles ahead of it, and return just
  // after the edge that accepts it. Sample tready mid-cycle to keep clear of
  // the edge.
  task automatic send_item(input logic [16:0] number, input logic row,
                           input logic [5:0] column);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {column, row, number};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // Hold the sender off until every expected byte has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (bytes_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Spread numbers over every field width, with some above the clamp.
  function automatic logic [16:0] pick_number();
    case ($urandom_range(7))
      0:       return 17'($urandom_range(9));
      1:       return 17'($urandom_range(99, 10));
      2:       return 17'($urandom_range(999, 100));
      3:       return 17'($urandom_range(9999, 1000));
      4:       return 17'($urandom_range(99999, 10000));
      5:       return 17'($urandom_range(131071, 100000));
      default: return 17'($urandom_range(131071));
    endcase
  endfunction

  function automatic logic [5:0] pick_column();
    if ($urandom_range(3) == 0) return 6'($urandom_range(63));
    return 6'($urandom_range(39));
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: blanking at every width, the clamp, internal zeros, the
    // column and row extremes including columns past the line end.
    send_item(17'd0,      1'b0, 6'd0);
    send_item(17'd99999,  1'b1, 6'd39);
    send_item(17'd100000, 1'b0, 6'd5);
    send_item(17'd131071, 1'b1, 6'd63);
    send_item(17'd1,      1'b0, 6'd40);
    send_item(17'd9,      1'b1, 6'd1);
    send_item(17'd10,     1'b0, 6'd63);
    send_item(17'd99,     1'b1, 6'd0);
    send_item(17'd100,    1'b0, 6'd20);
    send_item(17'd999,    1'b1, 6'd35);
    send_item(17'd1000,   1'b0, 6'd36);
    send_item(17'd9999,   1'b1, 6'd42);
    send_item(17'd10000,  1'b0, 6'd10);
    send_item(17'd10001,  1'b1, 6'd21);
    send_item(17'd90000,  1'b0, 6'd42);
    send_item(17'd12345,  1'b1, 6'd12);
    send_item(17'd50505,  1'b0, 6'd31);
    send_item(17'd65536,  1'b1, 6'd16);
    send_item(17'd43690,  1'b0, 6'd21);
    drain();

    // Random phases: no idling (first and last), sender idle, receiver stalling, both light.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1:       begin tx_idle_pct = 52; rx_stall_pct <= 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct <= 52; end
        3:       begin tx_idle_pct = 9;  rx_stall_pct <= 9;  end
        default: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
      endcase
      // Fill the block up behind a long receiver hold-off.
      if (p == 0) hold_req <= hold_req + 8'd1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        send_item(pick_number(), 1'($urandom_range(1)), pick_column());
        if (p == 0 && i == HOLD_ITEMS) drain();
      end
      drain();
    end

    // Watch for stray bytes after the last expected one.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && bytes_owed == 0) begin
      $display("[lcd_decimal_field_writer] OK");
    end else begin
      $display("[lcd_decimal_field_writer] ERROR");
    end
    $finish;
  end

endmodule
